/* rtl/plist_pkg.sv */
// package for the positional list engine: field widths, command codes and
// the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package plist_pkg;

    // default store depth
    localparam int CAPACITY_DEF = 64;

    // fixed field widths
    localparam int CMD_W       = 2;
    localparam int POS_W       = 7;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic take;      // capture the input item, clear the result
        logic idx_ins;   // cursor <= count
        logic idx_pos;   // cursor <= position - 1
        logic rd_prev;   // read cell cursor - 1
        logic rd_next;   // read cell cursor + 1
        logic rd_at;     // read cell cursor
        logic wr_shift;  // write read data at cursor
        logic wr_val;    // write item value at cursor
        logic idx_dec;
        logic idx_inc;
        logic grab;      // result value <= read data
        logic set_ok;
        logic len_inc;
        logic len_dec;
        logic out_load;  // move result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic ins_ok;    // insert in bounds and list not full
        logic del_ok;    // delete in bounds
        logic get_ok;    // get in bounds
        logic ins_at;    // cursor reached the insert cell
        logic del_end;   // cursor reached the last entry
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/positional_list_engine.sv */
// top level of the positional list engine: stream ports, controller and
// datapath; uses plist_pkg, plist_ctrl, plist_datapath
`default_nettype none

// Ordered list of signed 32-bit values, positions counted from 1, one
// command per item (insert, delete, get) and one result per item with ok,
// value and count. Insert and delete shift the entries from the position
// to the end of the list, one cell at a time, reading it and then writing
// it one place over; get and a failed command shift nothing. The result is
// loaded into the output register as the engine returns to idle.
// A finished result waits in the output register while the next item is
// accepted; a result that finds the output register still full holds in
// the last state until that register drains. The list is empty after
// reset with no clearing pass.
module positional_list_engine #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // cmd[1:0], position[8:2], value[40:9], zero fill above
    input  wire logic [plist_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // ok[0], read_value[32:1], entry_count[39:33]
    output logic      [plist_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    plist_pkg::t_dp_cmd  w_cmd;
    plist_pkg::t_dp_stat w_stat;

    plist_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    plist_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tdata (s_axis_tdata),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* rtl/plist_datapath.sv */
// datapath of the positional list engine: entry memory, count, cursor,
// bound checks and output register; uses plist_pkg
`default_nettype none

module plist_datapath #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [plist_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  wire plist_pkg::t_dp_cmd                  i_cmd,
    output plist_pkg::t_dp_stat                      o_stat,
    output logic      [plist_pkg::OUT_TDATA_W-1:0]   o_tdata
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = ((LW > plist_pkg::POS_W) ? LW : plist_pkg::POS_W) + 1;

    logic [plist_pkg::CMD_W-1:0]  r_cmd;
    logic [plist_pkg::POS_W-1:0]  r_pos;
    logic [plist_pkg::DATA_W-1:0] r_val;
    logic [LW-1:0]                r_len;
    logic [AW-1:0]                r_idx;
    logic [plist_pkg::DATA_W-1:0] r_rdata;
    logic [plist_pkg::DATA_W-1:0] r_res;
    logic                         r_ok;
    logic                         r_out_ok;
    logic [plist_pkg::DATA_W-1:0] r_out_val;
    logic [plist_pkg::CNT_W-1:0]  r_out_cnt;
    logic [plist_pkg::DATA_W-1:0] r_mem [CAPACITY];

    logic [CW-1:0]                w_pos_x;
    logic [CW-1:0]                w_len_x;
    logic [CW-1:0]                w_idx_x;
    logic [CW-1:0]                w_pos_m1;
    logic [AW-1:0]                w_rd_addr;
    logic                         w_rd_en;
    logic                         w_wr_en;
    logic [plist_pkg::DATA_W-1:0] w_wr_data;

    // widened operands for the bound checks
    assign w_pos_x  = CW'(r_pos);
    assign w_len_x  = CW'(r_len);
    assign w_idx_x  = CW'(r_idx);
    assign w_pos_m1 = w_pos_x - CW'(1);

    // status to the controller
    always_comb begin
        o_stat.ins_ok  = (r_cmd == plist_pkg::CMD_INSERT) && (r_pos != '0)
                         && (w_pos_x <= w_len_x + CW'(1))
                         && (w_len_x < CW'(CAPACITY));
        o_stat.del_ok  = (r_cmd == plist_pkg::CMD_DELETE) && (r_pos != '0)
                         && (w_pos_x <= w_len_x);
        o_stat.get_ok  = (r_cmd == plist_pkg::CMD_GET) && (r_pos != '0)
                         && (w_pos_x <= w_len_x);
        o_stat.ins_at  = (w_idx_x == w_pos_m1);
        o_stat.del_end = ((w_idx_x + CW'(1)) >= w_len_x);
    end

    // memory port selection
    always_comb begin
        if (i_cmd.rd_prev) begin
            w_rd_addr = r_idx - AW'(1);
        end else if (i_cmd.rd_next) begin
            w_rd_addr = r_idx + AW'(1);
        end else begin
            w_rd_addr = r_idx;
        end
        w_rd_en   = i_cmd.rd_prev | i_cmd.rd_next | i_cmd.rd_at;
        w_wr_en   = i_cmd.wr_shift | i_cmd.wr_val;
        w_wr_data = i_cmd.wr_shift ? r_rdata : r_val;
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_idx] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.len_inc) begin
            r_len <= r_len + LW'(1);
        end else if (i_cmd.len_dec) begin
            r_len <= r_len - LW'(1);
        end
    end

    // item capture, cursor and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cmd <= i_tdata[1:0];
            r_pos <= i_tdata[8:2];
            r_val <= i_tdata[40:9];
            r_ok  <= 1'b0;
            r_res <= '0;
        end else begin
            if (i_cmd.set_ok) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.grab) begin
                r_res <= r_rdata;
            end
        end
        if (i_cmd.idx_ins) begin
            r_idx <= w_len_x[AW-1:0];
        end else if (i_cmd.idx_pos) begin
            r_idx <= w_pos_m1[AW-1:0];
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - AW'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ok  <= r_ok;
            r_out_val <= r_res;
            r_out_cnt <= w_len_x[plist_pkg::CNT_W-1:0];
        end
    end

    assign o_tdata = {r_out_cnt, r_out_val, r_out_ok};

endmodule

`default_nettype wire

/* rtl/plist_ctrl.sv */
// controller of the positional list engine: sequences bound check, shift
// loops and result hand-off; uses plist_pkg
`default_nettype none

module plist_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_valid,
    output logic                       o_s_ready,
    output logic                       o_m_valid,
    input  wire logic                  i_m_ready,
    input  wire plist_pkg::t_dp_stat   i_stat,
    output plist_pkg::t_dp_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_INS_CHK = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_RD_AT   = 4'd4;
    localparam logic [3:0] S_GRAB    = 4'd5;
    localparam logic [3:0] S_DEL_CHK = 4'd6;
    localparam logic [3:0] S_DEL_WR  = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_m_valid;
    logic       n_m_valid;

    // next state and datapath commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.ins_ok) begin
                    o_cmd.idx_ins = 1'b1;
                    n_state       = S_INS_CHK;
                end else if (i_stat.del_ok || i_stat.get_ok) begin
                    o_cmd.idx_pos = 1'b1;
                    n_state       = S_RD_AT;
                end else begin
                    n_state = S_FIN;
                end
            end
            // shift cells up until the cursor reaches the insert cell
            S_INS_CHK: begin
                if (i_stat.ins_at) begin
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.len_inc = 1'b1;
                    o_cmd.set_ok  = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_dec  = 1'b1;
                n_state        = S_INS_CHK;
            end
            S_RD_AT: begin
                o_cmd.rd_at = 1'b1;
                n_state     = S_GRAB;
            end
            S_GRAB: begin
                o_cmd.grab   = 1'b1;
                o_cmd.set_ok = 1'b1;
                n_state      = i_stat.del_ok ? S_DEL_CHK : S_FIN;
            end
            // shift cells down until the cursor reaches the last entry
            S_DEL_CHK: begin
                if (i_stat.del_end) begin
                    o_cmd.len_dec = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_DEL_CHK;
            end
            S_FIN: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid follows loads and taken items
    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

endmodule

`default_nettype wire

/* rtl/plist_checker.sv */
// port-level checks for the positional list engine, bound to the top level
// uses plist_pkg
`default_nettype none

module plist_checker #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [plist_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // failed commands return zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
        else $error("failed command returned a nonzero value");

    // count never above capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[39:33]) <= CAPACITY))
        else $error("entry count above capacity");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind positional_list_engine plist_checker #(
    .CAPACITY (CAPACITY)
) u_plist_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
